### design/scag_pkg.sv
// Shared constants and types for the strided copy address generator.
package scag_pkg;

    localparam int NUM_AXES     = 3;
    localparam int DIM_BITS     = 16;
    localparam int STRIDE_BITS  = 24;
    localparam int POS_BITS     = 42;
    localparam int OFF_BITS     = 45;
    localparam int SHAPE_BITS   = NUM_AXES * DIM_BITS;
    localparam int ESIZE_BITS   = 2;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_BITS     = SHAPE_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_SHAPE_DIMS   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_OUTER    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_MIDDLE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_INNER    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DST_OUTER    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DST_MIDDLE   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_DST_INNER    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_ELEMENT_SIZE = 3'd7;

    typedef logic [DIM_BITS-1:0]    dim_t;
    typedef logic [STRIDE_BITS-1:0] stride_t;
    typedef logic [POS_BITS-1:0]    pos_t;
    typedef logic [OFF_BITS-1:0]    offset_t;

    typedef struct packed {
        logic step;
        logic restart;
        logic clear;
    } scag_cell_ctrl_t;

endpackage

### design/scag_axis_cell.sv
// One axis of the walk: index counter and the partial positions it contributes.
module scag_axis_cell
    import scag_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  scag_cell_ctrl_t ctrl,
    input  dim_t            dim,
    input  stride_t         src_stride,
    input  stride_t         dst_stride,
    input  logic            carry_in,
    output logic            carry_out,
    input  pos_t            src_base_in,
    input  pos_t            dst_base_in,
    output pos_t            src_base_out,
    output pos_t            dst_base_out
);

    dim_t count_reg, count_next;
    pos_t src_part_reg, src_part_next;
    pos_t dst_part_reg, dst_part_next;

    dim_t count_eff;
    dim_t count_inc;
    pos_t src_part_eff;
    pos_t dst_part_eff;
    logic wrap;

    always_comb
    begin
        count_eff    = ctrl.restart ? '0 : count_reg;
        src_part_eff = ctrl.restart ? '0 : src_part_reg;
        dst_part_eff = ctrl.restart ? '0 : dst_part_reg;
        count_inc    = count_eff + dim_t'(1);
        wrap         = (count_inc >= dim) || (count_inc == '0);
        carry_out    = carry_in & wrap;
        src_base_out = src_base_in + src_part_eff;
        dst_base_out = dst_base_in + dst_part_eff;
    end

    always_comb
    begin
        count_next    = count_reg;
        src_part_next = src_part_reg;
        dst_part_next = dst_part_reg;
        priority if (ctrl.clear)
        begin
            count_next    = '0;
            src_part_next = '0;
            dst_part_next = '0;
        end
        else if (ctrl.step)
        begin
            if (carry_in && wrap)
            begin
                count_next    = '0;
                src_part_next = '0;
                dst_part_next = '0;
            end
            else if (carry_in)
            begin
                count_next    = count_inc;
                src_part_next = src_part_eff + pos_t'(src_stride);
                dst_part_next = dst_part_eff + pos_t'(dst_stride);
            end
            else
            begin
                count_next    = count_eff;
                src_part_next = src_part_eff;
                dst_part_next = dst_part_eff;
            end
        end
        else
        begin
            count_next    = count_reg;
            src_part_next = src_part_reg;
            dst_part_next = dst_part_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            src_part_reg <= '0;
            dst_part_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            src_part_reg <= src_part_next;
            dst_part_reg <= dst_part_next;
        end
    end

endmodule

### design/strided_copy_address_generator.sv
// Top level: configuration registers, axis cell chain and output register.
// Result: an accepted transaction's result is registered in the output register.
// Throughput: one transaction per cycle unless a waiting result is stalled by out_ready
// low; the carry and position chain through the three axis cells is combinational.
// Reset: asynchronous active low; clears configuration registers, counters and output valid.
module strided_copy_address_generator
    import scag_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    restart,
    output logic                    out_valid,
    input  logic                    out_ready,
    output offset_t                 src_offset,
    output offset_t                 dst_offset,
    output logic                    last,
    output logic                    empty_res
);

    logic [SHAPE_BITS-1:0] shape_dims_reg;
    stride_t               src_stride_reg [NUM_AXES];
    stride_t               dst_stride_reg [NUM_AXES];
    logic [ESIZE_BITS-1:0] element_size_log2_reg;

    logic    out_valid_reg, out_valid_next;
    offset_t src_offset_reg;
    offset_t dst_offset_reg;
    logic    last_reg;
    logic    empty_reg;

    logic            accept;
    logic            shape_empty;
    scag_cell_ctrl_t cell_ctrl;
    dim_t            dim         [NUM_AXES];
    logic            carry       [NUM_AXES+1];
    pos_t            src_base    [NUM_AXES+1];
    pos_t            dst_base    [NUM_AXES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_dims_reg        <= '0;
            src_stride_reg        <= '{default: '0};
            dst_stride_reg        <= '{default: '0};
            element_size_log2_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_SHAPE_DIMS:   shape_dims_reg        <= cfg_data[SHAPE_BITS-1:0];
                REG_SRC_OUTER:    src_stride_reg[0]     <= cfg_data[STRIDE_BITS-1:0];
                REG_SRC_MIDDLE:   src_stride_reg[1]     <= cfg_data[STRIDE_BITS-1:0];
                REG_SRC_INNER:    src_stride_reg[2]     <= cfg_data[STRIDE_BITS-1:0];
                REG_DST_OUTER:    dst_stride_reg[0]     <= cfg_data[STRIDE_BITS-1:0];
                REG_DST_MIDDLE:   dst_stride_reg[1]     <= cfg_data[STRIDE_BITS-1:0];
                REG_DST_INNER:    dst_stride_reg[2]     <= cfg_data[STRIDE_BITS-1:0];
                REG_ELEMENT_SIZE: element_size_log2_reg <= cfg_data[ESIZE_BITS-1:0];
                default:          shape_dims_reg        <= shape_dims_reg;
            endcase
        end
    end

    always_comb
    begin
        shape_empty = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            dim[a] = shape_dims_reg[(NUM_AXES-1-a)*DIM_BITS +: DIM_BITS];
            if (dim[a] == '0)
            begin
                shape_empty = 1'b1;
            end
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cell_ctrl.step    = accept && !shape_empty;
        cell_ctrl.restart = restart;
        cell_ctrl.clear   = cfg_write_en || (accept && shape_empty);
    end

    assign carry[NUM_AXES] = 1'b1;
    assign src_base[0]     = '0;
    assign dst_base[0]     = '0;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        scag_axis_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (cell_ctrl),
            .dim          (dim[a]),
            .src_stride   (src_stride_reg[a]),
            .dst_stride   (dst_stride_reg[a]),
            .carry_in     (carry[a+1]),
            .carry_out    (carry[a]),
            .src_base_in  (src_base[a]),
            .dst_base_in  (dst_base[a]),
            .src_base_out (src_base[a+1]),
            .dst_base_out (dst_base[a+1])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (shape_empty)
            begin
                src_offset_reg <= '0;
                dst_offset_reg <= '0;
                last_reg       <= 1'b1;
                empty_reg      <= 1'b1;
            end
            else
            begin
                src_offset_reg <= offset_t'(src_base[NUM_AXES]) << element_size_log2_reg;
                dst_offset_reg <= offset_t'(dst_base[NUM_AXES]) << element_size_log2_reg;
                last_reg       <= carry[0];
                empty_reg      <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign src_offset = src_offset_reg;
    assign dst_offset = dst_offset_reg;
    assign last       = last_reg;
    assign empty_res  = empty_reg;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while result stalled");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted transaction produced no result");

    a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> last && src_offset == '0 && dst_offset == '0)
        else $error("empty shape result malformed");
`endif

endmodule

### sim/tb_strided_copy_address_generator.sv
// Testbench for the strided copy address generator: directed walks and random traffic.
`timescale 1ns / 1ps

module tb_strided_copy_address_generator;
    import scag_pkg::*;

    typedef struct packed {
        offset_t src;
        offset_t dst;
        logic    last;
        logic    empty;
    } addr_pair_t;

    localparam int WATCHDOG_LIMIT = 5000;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    restart;
    logic                    out_valid;
    logic                    out_ready;
    offset_t                 src_offset;
    offset_t                 dst_offset;
    logic                    last;
    logic                    empty_res;

    logic [SHAPE_BITS-1:0] shape_reg;
    stride_t               src_stride_reg [NUM_AXES];
    stride_t               dst_stride_reg [NUM_AXES];
    logic [ESIZE_BITS-1:0] esize_reg;
    dim_t                  walk_idx [NUM_AXES];

    addr_pair_t expected_pairs [$];
    int         error_count;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_off_left;
    int         idle_cycles;

    strided_copy_address_generator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .src_offset   (src_offset),
        .dst_offset   (dst_offset),
        .last         (last),
        .empty_res    (empty_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void rewind_walk();
        for (int a = 0; a < NUM_AXES; a++)
        begin
            walk_idx[a] = '0;
        end
    endfunction

    function automatic void set_register(input logic [CFG_IDX_BITS-1:0] idx,
                                         input logic [CFG_BITS-1:0] data);
        case (idx)
            REG_SHAPE_DIMS:   shape_reg = data[SHAPE_BITS-1:0];
            REG_SRC_OUTER:    src_stride_reg[0] = data[STRIDE_BITS-1:0];
            REG_SRC_MIDDLE:   src_stride_reg[1] = data[STRIDE_BITS-1:0];
            REG_SRC_INNER:    src_stride_reg[2] = data[STRIDE_BITS-1:0];
            REG_DST_OUTER:    dst_stride_reg[0] = data[STRIDE_BITS-1:0];
            REG_DST_MIDDLE:   dst_stride_reg[1] = data[STRIDE_BITS-1:0];
            REG_DST_INNER:    dst_stride_reg[2] = data[STRIDE_BITS-1:0];
            REG_ELEMENT_SIZE: esize_reg = data[ESIZE_BITS-1:0];
            default: ;
        endcase
        rewind_walk();
    endfunction

    function automatic addr_pair_t next_address_pair(input logic rs);
        dim_t       len [NUM_AXES];
        pos_t       sp;
        pos_t       dp;
        dim_t       nxt;
        logic       is_empty;
        logic       carry;
        addr_pair_t r;
        is_empty = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            len[a] = shape_reg[(NUM_AXES-1-a)*DIM_BITS +: DIM_BITS];
            if (len[a] == '0)
                is_empty = 1'b1;
        end
        if (is_empty)
        begin
            rewind_walk();
            r.src = '0;
            r.dst = '0;
            r.last = 1'b1;
            r.empty = 1'b1;
            return r;
        end
        if (rs)
            rewind_walk();
        sp = '0;
        dp = '0;
        r.last = 1'b1;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sp = sp + pos_t'(walk_idx[a]) * pos_t'(src_stride_reg[a]);
            dp = dp + pos_t'(walk_idx[a]) * pos_t'(dst_stride_reg[a]);
            if (walk_idx[a] != dim_t'(len[a] - 1'b1))
                r.last = 1'b0;
        end
        r.src = offset_t'(sp) << esize_reg;
        r.dst = offset_t'(dp) << esize_reg;
        r.empty = 1'b0;
        carry = 1'b1;
        for (int a = NUM_AXES - 1; a >= 0; a--)
        begin
            if (carry)
            begin
                nxt = walk_idx[a] + 1'b1;
                if (nxt < len[a] && nxt != '0)
                begin
                    walk_idx[a] = nxt;
                    carry = 1'b0;
                end
                else
                    walk_idx[a] = '0;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [OFF_BITS-1:0] got,
                                   input logic [OFF_BITS-1:0] want);
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_request(input logic rs);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            restart = 1'($urandom_range(1));
            @(negedge clk);
        end
        in_valid = 1'b1;
        restart = rs;
        do
            @(posedge clk);
        while (!in_ready);
        expected_pairs.insert(expected_pairs.size(), next_address_pair(rs));
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        restart = 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_BITS-1:0] data);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_write_en = 1'b0;
        cfg_index = CFG_IDX_BITS'($urandom);
        cfg_data = CFG_BITS'({$urandom, $urandom});
        set_register(idx, data);
    endtask

    task automatic write_layout(input dim_t outer, input dim_t middle, input dim_t inner,
                                input stride_t so, input stride_t sm, input stride_t si,
                                input stride_t d_o, input stride_t dm, input stride_t di,
                                input logic [ESIZE_BITS-1:0] es);
        write_register(REG_SHAPE_DIMS, {outer, middle, inner});
        write_register(REG_SRC_OUTER, CFG_BITS'(so));
        write_register(REG_SRC_MIDDLE, CFG_BITS'(sm));
        write_register(REG_SRC_INNER, CFG_BITS'(si));
        write_register(REG_DST_OUTER, CFG_BITS'(d_o));
        write_register(REG_DST_MIDDLE, CFG_BITS'(dm));
        write_register(REG_DST_INNER, CFG_BITS'(di));
        write_register(REG_ELEMENT_SIZE, CFG_BITS'(es));
    endtask

    function automatic dim_t pick_axis_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return '0;
        else if (roll < 73)
            return dim_t'($urandom_range(1, 4));
        else if (roll < 95)
            return dim_t'($urandom_range(5, 40));
        else
            return dim_t'($urandom);
    endfunction

    function automatic stride_t pick_stride();
        case ($urandom_range(4))
            0:       return '0;
            1:       return stride_t'(1);
            2:       return '1;
            3:       return stride_t'($urandom_range(2, 300));
            default: return stride_t'($urandom);
        endcase
    endfunction

    task automatic configure_random();
        logic [CFG_BITS-1:0] data;
        for (int i = 0; i < 8; i++)
        begin
            if ($urandom_range(99) < 85)
            begin
                data = CFG_BITS'({$urandom, $urandom});
                if (i == REG_SHAPE_DIMS)
                    data = {pick_axis_len(), pick_axis_len(), pick_axis_len()};
                else if (i != REG_ELEMENT_SIZE)
                    data[STRIDE_BITS-1:0] = pick_stride();
                write_register(CFG_IDX_BITS'(i), data);
            end
        end
    endtask

    task automatic test_empty_after_reset();
        send_request(1'b0);
        send_request(1'b1);
        wait_drain();
    endtask

    task automatic test_full_walk();
        write_layout(16'd1, 16'd2, 16'd3, 24'd100, 24'd12, 24'd1,
                     24'd7, 24'd1, 24'd9, 2'd2);
        repeat (7) send_request(1'b0);
        wait_drain();
    endtask

    task automatic test_restart_and_rewrite();
        repeat (3) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_drain();
        write_register(REG_ELEMENT_SIZE, CFG_BITS'(1));
        send_request(1'b0);
        wait_drain();
    endtask

    task automatic test_extremes();
        for (int i = 0; i < 8; i++)
        begin
            write_register(CFG_IDX_BITS'(i), '1);
        end
        repeat (3) send_request(1'b0);
        wait_drain();
        for (int a = 0; a < NUM_AXES; a++)
        begin
            write_register(REG_SHAPE_DIMS,
                           ~(CFG_BITS'({DIM_BITS{1'b1}}) << ((NUM_AXES-1-a)*DIM_BITS)));
            send_request(a[0]);
            wait_drain();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drain();
        write_layout(16'd3, 16'd4, 16'd5, 24'd400, 24'd50, 24'd2,
                     24'd1, 24'd3, 24'd12, 2'd3);
        hold_off_left = 200;
        repeat (40) send_request($urandom_range(99) < 4);
        wait_drain();
        repeat (15) send_request(1'b0);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int budget, input int idle, input int stall);
        int sent;
        int n;
        sent = 0;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        while (sent < budget)
        begin
            wait_drain();
            configure_random();
            n = $urandom_range(10, 90);
            repeat (n) send_request($urandom_range(99) < 4);
            sent += n;
        end
        wait_drain();
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                out_ready = 1'b0;
                hold_off_left--;
            end
            else
                out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        addr_pair_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pairs.size() == 0)
                report_mismatch("transaction with nothing expected", src_offset, '0);
            else
            begin
                want = expected_pairs.pop_front();
                if (src_offset !== want.src)
                    report_mismatch("src_offset", src_offset, want.src);
                if (dst_offset !== want.dst)
                    report_mismatch("dst_offset", dst_offset, want.dst);
                if (last !== want.last)
                    report_mismatch("last", OFF_BITS'(last), OFF_BITS'(want.last));
                if (empty_res !== want.empty)
                    report_mismatch("empty_res", OFF_BITS'(empty_res), OFF_BITS'(want.empty));
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        restart = 1'b0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_left = 0;
        shape_reg = '0;
        esize_reg = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            src_stride_reg[a] = '0;
            dst_stride_reg[a] = '0;
        end
        rewind_walk();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_empty_after_reset();
        test_full_walk();
        test_restart_and_rewrite();
        test_extremes();
        test_backpressure();
        test_random_traffic(460, 0, 0);
        test_random_traffic(440, 76, 0);
        test_random_traffic(440, 0, 76);
        test_random_traffic(400, 19, 19);

        wait_drain();
        if (error_count == 0 && expected_pairs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
design/scag_pkg.sv
design/scag_axis_cell.sv
design/strided_copy_address_generator.sv
sim/tb_strided_copy_address_generator.sv
